>>> design/bitmap_id_allocator_unit_macros.svh
// assertion macros used by the bitmap id allocator controller, bia_ctrl
`ifndef BITMAP_ID_ALLOCATOR_UNIT_MACROS_SVH
`define BITMAP_ID_ALLOCATOR_UNIT_MACROS_SVH

// same-cycle implication, checked out of reset
`define BIA_ASSERT_IMPL(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("bitmap id allocator: assertion failed");

// next-cycle implication, checked out of reset
`define BIA_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("bitmap id allocator: assertion failed");

`endif

>>> design/bia_pkg.sv
// types and constants shared by the bitmap id allocator modules
package bia_pkg;

   localparam int LANES  = 8;   // bitmap bytes per memory word
   localparam int LANE_W = 3;
   localparam int SIZE_W = 13;  // width of bytes_in_use and of the size in effect
   localparam int CAP_W  = 16;
   localparam int WCNT_W = 11;  // word counter, holds one past the last word
   localparam int WIDX_W = 10;  // word number of a byte within the size in effect

   localparam logic [SIZE_W-1:0] BYTES_IN_USE_RESET = 13'd4096;
   localparam logic [0:0]        REG_BYTES_IN_USE   = 1'b0;

   localparam logic [1:0] OP_ALLOC   = 2'd0;
   localparam logic [1:0] OP_RELEASE = 2'd1;
   localparam logic [1:0] OP_LOAD    = 2'd2;
   localparam logic [1:0] OP_SET     = 2'd3;

   localparam logic [2:0] ST_OK           = 3'd0;
   localparam logic [2:0] ST_OVER_CAP     = 3'd1;
   localparam logic [2:0] ST_NO_FREE      = 3'd2;
   localparam logic [2:0] ST_ALREADY_FREE = 3'd3;
   localparam logic [2:0] ST_RANGE        = 3'd4;

   typedef logic [LANES-1:0][7:0] mem_word_type;

   typedef struct packed {
      logic [SIZE_W-1:0] size;
      logic [CAP_W-1:0]  cap;
   } cfg_type;

   typedef struct packed {
      logic              rd_en;
      logic              wr_en;
      logic [LANE_W-1:0] wr_lane;
      logic [7:0]        wr_byte;
   } mem_cmd_type;

endpackage

>>> design/bia_mem.sv
// bitmap store: word-wide synchronous memory with a byte-lane write
module bia_mem
   import bia_pkg::*;
#(
   parameter int WORDS = 512,
   parameter int AW    = 9
) (
   input  logic              clock,
   input  mem_cmd_type       cmd,
   input  logic [AW-1:0]     rd_addr,
   input  logic [AW-1:0]     wr_addr,
   output mem_word_type      rd_data
);

   mem_word_type mem_ff [WORDS];
   mem_word_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem_ff[wr_addr][cmd.wr_lane] <= cmd.wr_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/bia_csr.sv
// configuration register block: bytes_in_use and the derived size and capacity
module bia_csr
   import bia_pkg::*;
#(
   parameter int BITMAP_BYTES = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output cfg_type     cfg
);

   logic [SIZE_W-1:0] bytes_ff;
   logic [SIZE_W-1:0] bytes_in;
   logic              reg_hit;

   assign reg_hit = (csr_paddr[2:2] == REG_BYTES_IN_USE);

   always_comb begin
      bytes_in = bytes_ff;
      if (csr_psel && csr_penable && csr_pwrite && reg_hit) begin
         bytes_in = csr_pwdata[SIZE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_ff <= BYTES_IN_USE_RESET;
      end else begin
         bytes_ff <= bytes_in;
      end
   end

   // size saturates at the store depth
   always_comb begin
      if (32'(bytes_ff) > BITMAP_BYTES) begin
         cfg.size = SIZE_W'(BITMAP_BYTES);
      end else begin
         cfg.size = bytes_ff;
      end
      cfg.cap = {cfg.size, 3'b000};
   end

   assign csr_prdata = reg_hit ? 32'(bytes_ff) : 32'd0;
   assign csr_pready = 1'b1;

endmodule

>>> design/bia_ctrl.sv
// operation sequencer: read-modify-write of the bitmap store, byte load, free count set, word scan, result register
`include "bitmap_id_allocator_unit_macros.svh"
module bia_ctrl
   import bia_pkg::*;
#(
   parameter int BITMAP_BYTES = 4096,
   parameter int AW           = 9
) (
   input  logic          clock,
   input  logic          reset,
   input  cfg_type       cfg,
   input  logic          req_valid,
   output logic          req_stall,
   input  logic [1:0]    req_operation,
   input  logic [14:0]   req_index,
   input  logic [15:0]   req_value,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output logic [14:0]   rsp_allocated_id,
   output logic [2:0]    rsp_status,
   output logic [15:0]   rsp_free_now,
   output mem_cmd_type   mem_cmd,
   output logic [AW-1:0] mem_rd_addr,
   output logic [AW-1:0] mem_wr_addr,
   input  mem_word_type  mem_rd_data
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_EXEC  = 3'd1;
   localparam logic [2:0] S_SCAN  = 3'd2;
   localparam logic [2:0] S_RWAIT = 3'd3;
   localparam logic [2:0] S_WB    = 3'd4;
   localparam logic [2:0] S_DONE  = 3'd5;

   logic [2:0]        state_ff, state_in;
   logic [1:0]        op_ff, op_in;
   logic [14:0]       idx_ff, idx_in;
   logic [15:0]       val_ff, val_in;
   logic [CAP_W-1:0]  free_ff, free_in;
   logic [WCNT_W-1:0] issue_ff, issue_in;
   logic [WCNT_W-1:0] chk_ff, chk_in;
   logic              pend_ff, pend_in;
   logic [LANE_W-1:0] hit_lane_ff, hit_lane_in;
   logic [7:0]        hit_byte_ff, hit_byte_in;
   logic [14:0]       res_id_ff, res_id_in;
   logic [2:0]        res_status_ff, res_status_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [14:0]       rsp_id_ff, rsp_id_in;
   logic [2:0]        rsp_status_ff, rsp_status_in;
   logic [15:0]       rsp_free_ff, rsp_free_in;

   logic [SIZE_W-1:0] size_less1;
   logic [WIDX_W-1:0] last_word;
   logic [WCNT_W-1:0] last_word_ext;
   logic [CAP_W:0]    free_inc;
   logic [LANES-1:0]  lane_ok;
   logic [LANE_W-1:0] hit_lane;
   logic [LANE_W-1:0] hit_bit;
   logic [7:0]        sel_byte;
   logic [7:0]        rel_byte;
   logic              found;

   assign size_less1    = cfg.size - SIZE_W'(1);
   assign last_word     = size_less1[SIZE_W-1:LANE_W];
   assign last_word_ext = {1'b0, last_word};
   assign free_inc      = {1'b0, free_ff} + 17'd1;
   assign rel_byte      = mem_rd_data[idx_ff[5:3]];

   // lowest non-empty byte inside the size, then its lowest set bit
   always_comb begin
      lane_ok  = '0;
      hit_lane = '0;
      hit_bit  = '0;
      for (int l = 0; l < LANES; l++) begin
         lane_ok[l] = ({chk_ff[WIDX_W-1:0], LANE_W'(l)} < cfg.size) &&
                      (mem_rd_data[l] != 8'd0);
      end
      for (int l = LANES - 1; l >= 0; l--) begin
         if (lane_ok[l]) begin
            hit_lane = LANE_W'(l);
         end
      end
      found    = pend_ff && (lane_ok != '0);
      sel_byte = mem_rd_data[hit_lane];
      for (int b = 7; b >= 0; b--) begin
         if (sel_byte[b]) begin
            hit_bit = LANE_W'(b);
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      idx_in        = idx_ff;
      val_in        = val_ff;
      free_in       = free_ff;
      issue_in      = issue_ff;
      chk_in        = chk_ff;
      pend_in       = 1'b0;
      hit_lane_in   = hit_lane_ff;
      hit_byte_in   = hit_byte_ff;
      res_id_in     = res_id_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_id_in     = rsp_id_ff;
      rsp_status_in = rsp_status_ff;
      rsp_free_in   = rsp_free_ff;
      mem_cmd       = '0;
      mem_rd_addr   = '0;
      mem_wr_addr   = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in    = req_operation;
               idx_in   = req_index;
               val_in   = req_value;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            res_status_in = ST_OK;
            res_id_in     = '0;
            state_in      = S_DONE;
            case (op_ff)
               OP_ALLOC: begin
                  if (free_ff > cfg.cap) begin
                     res_status_in = ST_OVER_CAP;
                  end else if (cfg.size == '0) begin
                     res_status_in = ST_NO_FREE;
                  end else begin
                     mem_cmd.rd_en = 1'b1;
                     mem_rd_addr   = '0;
                     issue_in      = WCNT_W'(1);
                     chk_in        = '0;
                     pend_in       = 1'b1;
                     state_in      = S_SCAN;
                  end
               end
               OP_RELEASE: begin
                  if (free_inc > {1'b0, cfg.cap}) begin
                     res_status_in = ST_OVER_CAP;
                  end else if ({1'b0, idx_ff[14:3]} >= cfg.size) begin
                     res_status_in = ST_RANGE;
                  end else begin
                     mem_cmd.rd_en = 1'b1;
                     mem_rd_addr   = AW'(idx_ff[14:6]);
                     state_in      = S_RWAIT;
                  end
               end
               OP_LOAD: begin
                  if (32'(idx_ff) >= BITMAP_BYTES) begin
                     res_status_in = ST_RANGE;
                  end else begin
                     mem_cmd.wr_en   = 1'b1;
                     mem_cmd.wr_lane = idx_ff[2:0];
                     mem_cmd.wr_byte = val_ff[7:0];
                     mem_wr_addr     = AW'(idx_ff[14:3]);
                  end
               end
               default: begin
                  free_in = val_ff;
                  if (val_ff > cfg.cap) begin
                     res_status_in = ST_OVER_CAP;
                  end
               end
            endcase
         end
         S_SCAN: begin
            // reads stream one word a cycle; data lags the issue counter by one
            if (found) begin
               hit_lane_in = hit_lane;
               hit_byte_in = sel_byte & ~(8'd1 << hit_bit);
               res_id_in   = 15'({chk_ff[WIDX_W-1:0], hit_lane, hit_bit});
               state_in    = S_WB;
            end else if (pend_ff && (chk_ff == last_word_ext)) begin
               res_status_in = ST_NO_FREE;
               state_in      = S_DONE;
            end else if (issue_ff <= last_word_ext) begin
               mem_cmd.rd_en = 1'b1;
               mem_rd_addr   = AW'(issue_ff);
               chk_in        = issue_ff;
               pend_in       = 1'b1;
               issue_in      = issue_ff + WCNT_W'(1);
            end
         end
         S_RWAIT: begin
            if (rel_byte[idx_ff[2:0]]) begin
               res_status_in = ST_ALREADY_FREE;
            end else begin
               mem_cmd.wr_en   = 1'b1;
               mem_cmd.wr_lane = idx_ff[5:3];
               mem_cmd.wr_byte = rel_byte | (8'd1 << idx_ff[2:0]);
               mem_wr_addr     = AW'(idx_ff[14:6]);
               free_in         = free_inc[CAP_W-1:0];
            end
            state_in = S_DONE;
         end
         S_WB: begin
            mem_cmd.wr_en   = 1'b1;
            mem_cmd.wr_lane = hit_lane_ff;
            mem_cmd.wr_byte = hit_byte_ff;
            mem_wr_addr     = AW'(chk_ff);
            if (free_ff != '0) begin
               free_in = free_ff - CAP_W'(1);
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_id_in     = res_id_ff;
               rsp_status_in = res_status_ff;
               rsp_free_in   = free_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         free_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         free_ff      <= free_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      idx_ff        <= idx_in;
      val_ff        <= val_in;
      issue_ff      <= issue_in;
      chk_ff        <= chk_in;
      hit_lane_ff   <= hit_lane_in;
      hit_byte_ff   <= hit_byte_in;
      res_id_ff     <= res_id_in;
      res_status_ff <= res_status_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_status_ff <= rsp_status_in;
      rsp_free_ff   <= rsp_free_in;
   end

   assign req_stall        = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_allocated_id = rsp_id_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_free_now     = rsp_free_ff;

   `BIA_ASSERT_NEXT(a_idle_free_hold, state_ff == S_IDLE, free_ff == $past(free_ff))
   `BIA_ASSERT_NEXT(a_rsp_only_from_done, state_ff != S_DONE && !rsp_valid_ff, !rsp_valid_ff)
   `BIA_ASSERT_IMPL(a_scan_in_range, state_ff == S_SCAN && mem_cmd.rd_en, issue_ff <= last_word_ext)
   `BIA_ASSERT_NEXT(a_alloc_count, state_ff == S_WB, free_ff == $past(free_ff) - 16'd1 || $past(free_ff) == 16'd0)

endmodule

>>> design/bitmap_id_allocator_unit.sv
// from accept to result transfer, set count, load and any refused request pass through S_EXEC
// and S_DONE; a release that reaches the store adds S_RWAIT for its store read
// allocate: words of eight bytes are scanned in S_SCAN, one a cycle, and a hit is written back in S_WB;
// the scan covers up to ceil(min(bytes_in_use, BITMAP_BYTES) / 8) words (512 at 4096)
// one request in flight: the next is taken once the result is registered
// reset: free count 0, bytes_in_use 4096; bitmap store not cleared, undefined until loaded
module bitmap_id_allocator_unit
   import bia_pkg::*;
#(
   parameter int BITMAP_BYTES = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_operation,
   input  logic [14:0] req_index,
   input  logic [15:0] req_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [14:0] rsp_allocated_id,
   output logic [2:0]  rsp_status,
   output logic [15:0] rsp_free_now,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int WORDS = (BITMAP_BYTES + LANES - 1) / LANES;
   localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;

   cfg_type       cfg;
   mem_cmd_type   mem_cmd;
   logic [AW-1:0] mem_rd_addr;
   logic [AW-1:0] mem_wr_addr;
   mem_word_type  mem_rd_data;

   bia_csr #(
      .BITMAP_BYTES(BITMAP_BYTES)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   bia_mem #(
      .WORDS(WORDS),
      .AW   (AW)
   ) u_mem (
      .clock   (clock),
      .cmd     (mem_cmd),
      .rd_addr (mem_rd_addr),
      .wr_addr (mem_wr_addr),
      .rd_data (mem_rd_data)
   );

   bia_ctrl #(
      .BITMAP_BYTES(BITMAP_BYTES),
      .AW          (AW)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_index        (req_index),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_allocated_id (rsp_allocated_id),
      .rsp_status       (rsp_status),
      .rsp_free_now     (rsp_free_now),
      .mem_cmd          (mem_cmd),
      .mem_rd_addr      (mem_rd_addr),
      .mem_wr_addr      (mem_wr_addr),
      .mem_rd_data      (mem_rd_data)
   );

endmodule
